@@ hw/rtl/kfq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfq_pkg
// Shared types and codes for the keyed order queue.
// ----------------------------------------------------------------------------
package kfq_pkg;

    typedef enum logic [1:0] {
        CMD_PUT    = 2'd0,
        CMD_PULL   = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_BUMP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_FULL      = 2'd1,
        STS_EMPTY     = 2'd2,
        STS_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_EXEC = 1'b1
    } fsm_t;

    typedef struct packed {
        logic pull;
        logic search;
        logic shift_en;
        logic load_en;
    } cell_ctrl_t;

endpackage

@@ hw/rtl/kfq_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfq_cell
// One queue slot: holds a key and compares it against the incoming key; loads
// that key when selected, else takes its neighbor's on a gap at or before it.
// ----------------------------------------------------------------------------
module kfq_cell #(
    parameter int IDX       = 0,
    parameter int KEY_WIDTH = 32,
    parameter int CW        = 5
) (
    input  logic                  clk,
    input  logic                  capture,
    input  logic [KEY_WIDTH-1:0]  key_in,
    input  kfq_pkg::cell_ctrl_t   ctrl,
    input  logic [CW-1:0]         count,
    input  logic [CW-1:0]         load_idx,
    input  logic [KEY_WIDTH-1:0]  next_key,
    input  logic                  hit_in,
    output logic [KEY_WIDTH-1:0]  slot_key,
    output logic                  hit_out,
    output logic                  tail_hit
);
    import kfq_pkg::*;

    logic [KEY_WIDTH-1:0] slot_reg;
    logic [KEY_WIDTH-1:0] slot_next;
    logic                 match_reg;
    logic                 match_next;
    logic                 occupied;
    logic                 gap;

    assign occupied = CW'(IDX) < count;
    assign gap      = hit_in | (ctrl.search & match_reg & occupied);
    assign hit_out  = gap;
    assign tail_hit = match_reg & (CW'(IDX + 1) == count);
    assign slot_key = slot_reg;

    always_comb
    begin
        slot_next  = slot_reg;
        match_next = match_reg;
        if (capture)
        begin
            match_next = (slot_reg == key_in);
        end
        if (ctrl.load_en && (load_idx == CW'(IDX)))
        begin
            slot_next = key_in;
        end
        else if (ctrl.shift_en && gap)
        begin
            slot_next = next_key;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg  <= slot_next;
        match_reg <= match_next;
    end

endmodule

@@ hw/rtl/keyed_fifo_with_remove_and_bump.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_fifo_with_remove_and_bump
// Ordered key queue with put, pull, remove by key and bump to tail.
// Result: the key compare is captured at the input transfer; in the EXEC state
//   the priority chain and shift across the cell row run and the result is
//   registered, held back while out_stall holds a pending result.
// Issue: a new command is taken only when idle; in_stall holds it off.
// Reset: rst_n clears the entry count and handshake state; slot keys are
//   left as they are and only slots below the count are ever used.
// ----------------------------------------------------------------------------
module keyed_fifo_with_remove_and_bump #(
    parameter int CAPACITY  = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [31:0] key,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] key_out,
    output logic [1:0]  status,
    output logic [4:0]  occupancy
);
    import kfq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    fsm_t                 state_reg;
    fsm_t                 state_next;
    cmd_t                 cmd_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] key_in_w;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [31:0]          key_out_reg;
    logic [31:0]          key_out_next;
    status_t              status_reg;
    status_t              status_next;
    logic [4:0]           occ_reg;
    logic [4:0]           occ_next;

    logic                 accept;
    logic                 go;
    cell_ctrl_t           ctrl;
    logic [CW-1:0]        load_idx;
    logic [KEY_WIDTH-1:0] cell_key   [CAPACITY];
    logic [CAPACITY:0]    hit_chain;
    logic [CAPACITY-1:0]  tail_vec;
    logic                 found;
    logic                 tail_hit;
    logic                 empty;
    logic                 full;
    logic [KEY_WIDTH-1:0] result_key;
    logic [31:0]          result_key_32;

    // key tag from the 32-bit port
    generate
        if (KEY_WIDTH <= 32)
        begin : g_key_narrow
            assign key_in_w      = key[KEY_WIDTH-1:0];
            assign result_key_32 = 32'(result_key);
        end
        else
        begin : g_key_wide
            assign key_in_w      = {{(KEY_WIDTH - 32){1'b0}}, key};
            assign result_key_32 = result_key[31:0];
        end
    endgenerate

    assign in_stall  = (state_reg != FSM_IDLE);
    assign accept    = in_valid && !in_stall;
    assign go        = (state_reg == FSM_EXEC) && !(out_valid_reg && out_stall);
    assign out_valid = out_valid_reg;
    assign key_out   = key_out_reg;
    assign status    = status_reg;
    assign occupancy = occ_reg;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CW'(CAPACITY));
    assign found     = hit_chain[CAPACITY];
    assign tail_hit  = |tail_vec;
    assign hit_chain[0] = ctrl.pull;

    // cell row
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [KEY_WIDTH-1:0] nbr_key;
            if (gi == CAPACITY - 1)
            begin : g_last
                assign nbr_key = cell_key[gi];
            end
            else
            begin : g_mid
                assign nbr_key = cell_key[gi + 1];
            end
            kfq_cell #(
                .IDX       (gi),
                .KEY_WIDTH (KEY_WIDTH),
                .CW        (CW)
            ) u_cell (
                .clk      (clk),
                .capture  (accept),
                .key_in   (accept ? key_in_w : key_reg),
                .ctrl     (ctrl),
                .count    (count_reg),
                .load_idx (load_idx),
                .next_key (nbr_key),
                .hit_in   (hit_chain[gi]),
                .slot_key (cell_key[gi]),
                .hit_out  (hit_chain[gi + 1]),
                .tail_hit (tail_vec[gi])
            );
        end
    endgenerate

    // command decode and result
    always_comb
    begin
        ctrl.pull     = 1'b0;
        ctrl.search   = (cmd_reg == CMD_REMOVE) || (cmd_reg == CMD_BUMP);
        ctrl.shift_en = 1'b0;
        ctrl.load_en  = 1'b0;
        load_idx      = count_reg;
        count_next    = count_reg;
        status_next   = STS_OK;
        result_key    = key_reg;
        case (cmd_reg)
            CMD_PUT:
            begin
                if (full)
                begin
                    status_next = STS_FULL;
                end
                else
                begin
                    ctrl.load_en = go;
                    count_next   = count_reg + 1'b1;
                end
            end
            CMD_PULL:
            begin
                ctrl.pull = 1'b1;
                if (empty)
                begin
                    status_next = STS_EMPTY;
                    result_key  = '0;
                end
                else
                begin
                    result_key    = cell_key[0];
                    ctrl.shift_en = go;
                    count_next    = count_reg - 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                if (found)
                begin
                    ctrl.shift_en = go;
                    count_next    = count_reg - 1'b1;
                end
                else
                begin
                    status_next = STS_NOT_FOUND;
                end
            end
            CMD_BUMP:
            begin
                load_idx = count_reg - 1'b1;
                if (tail_hit)
                begin
                    status_next = STS_OK;
                end
                else if (found)
                begin
                    ctrl.shift_en = go;
                    ctrl.load_en  = go;
                end
                else
                begin
                    status_next = STS_NOT_FOUND;
                end
            end
            default:
            begin
                status_next = STS_NOT_FOUND;
            end
        endcase
    end

    // handshake and output register
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        key_out_next   = key_out_reg;
        occ_next       = occ_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                if (go)
                begin
                    state_next     = FSM_IDLE;
                    out_valid_next = 1'b1;
                    key_out_next   = result_key_32;
                    occ_next       = 5'(count_next);
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (go)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_t'(cmd);
            key_reg <= key_in_w;
        end
        if (go)
        begin
            status_reg <= status_next;
        end
        key_out_reg <= key_out_next;
        occ_reg     <= occ_next;
    end

endmodule

@@ tb/tb_keyed_fifo_with_remove_and_bump.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_fifo_with_remove_and_bump
// Self-checking bench for the keyed order queue. A directed table covers the
// empty and full cases, the key extremes, duplicate keys, bump when the tail
// already matches and misses. Random traffic then swings the fill level
// between empty and full. Results are checked against a queue-based predictor
// or a typed table entry, with random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb_keyed_fifo_with_remove_and_bump;

    import kfq_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_ITEMS = 700;
    localparam int IDLE_LIMIT   = 2000;

    typedef struct packed {
        logic [31:0] key_out;
        status_t     status;
        logic [4:0]  occupancy;
    } qresult_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] key;
        logic        typed;
        qresult_t    want;
    } qrow_t;

    localparam qrow_t DIRECTED_ROWS [25] = '{
        '{CMD_PULL,   32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, STS_EMPTY,     5'd0}},
        '{CMD_REMOVE, 32'h1234_5678, 1'b1, '{32'h1234_5678, STS_NOT_FOUND, 5'd0}},
        '{CMD_BUMP,   32'hA5A5_A5A5, 1'b1, '{32'hA5A5_A5A5, STS_NOT_FOUND, 5'd0}},
        '{CMD_PUT,    32'h0000_0000, 1'b0, '0},
        '{CMD_PUT,    32'hFFFF_FFFF, 1'b0, '0},
        '{CMD_PUT,    32'h0000_0005, 1'b0, '0},
        '{CMD_PUT,    32'h8000_0000, 1'b0, '0},
        '{CMD_PUT,    32'h0000_0001, 1'b0, '0},
        '{CMD_PUT,    32'h5555_5555, 1'b0, '0},
        '{CMD_PUT,    32'hAAAA_AAAA, 1'b0, '0},
        '{CMD_PUT,    32'h0000_0005, 1'b0, '0},
        '{CMD_PUT,    32'h7FFF_FFFF, 1'b0, '0},
        '{CMD_PUT,    32'h0000_1234, 1'b0, '0},
        '{CMD_PUT,    32'hFFFF_FFFF, 1'b0, '0},
        '{CMD_PUT,    32'h3C3C_3C3C, 1'b0, '0},
        '{CMD_PUT,    32'hC3C3_C3C3, 1'b0, '0},
        '{CMD_PUT,    32'h0F0F_0F0F, 1'b0, '0},
        '{CMD_PUT,    32'hF0F0_F0F0, 1'b0, '0},
        '{CMD_PUT,    32'h0000_0005, 1'b0, '0},
        '{CMD_PUT,    32'hDEAD_0000, 1'b1, '{32'hDEAD_0000, STS_FULL,      5'd16}},
        '{CMD_BUMP,   32'h0000_0005, 1'b0, '0},
        '{CMD_BUMP,   32'hFFFF_FFFF, 1'b0, '0},
        '{CMD_REMOVE, 32'h0000_0005, 1'b0, '0},
        '{CMD_REMOVE, 32'hDEAD_BEEF, 1'b1, '{32'hDEAD_BEEF, STS_NOT_FOUND, 5'd15}},
        '{CMD_PULL,   32'h0000_0000, 1'b0, '0}
    };

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd       = 2'd0;
    logic [31:0] key       = 32'h0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] key_out;
    logic [1:0]  status;
    logic [4:0]  occupancy;

    logic [31:0] order_q[$];
    qresult_t    pending_results[$];
    int          error_count = 0;
    int          burst_left  = 0;
    int          idle_cycles = 0;
    logic [7:0]  stall_cycle = 8'd0;

    keyed_fifo_with_remove_and_bump dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .key       (key),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .key_out   (key_out),
        .status    (status),
        .occupancy (occupancy)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic qresult_t predict_order(cmd_t c, logic [31:0] k);
        qresult_t r;
        int       hit;
        r.key_out = k;
        r.status  = STS_OK;
        hit       = -1;
        for (int i = 0; i < order_q.size(); i++)
        begin
            if (hit < 0 && order_q[i] == k)
                hit = i;
        end
        case (c)
            CMD_PUT:
            begin
                if (order_q.size() >= CAPACITY)
                    r.status = STS_FULL;
                else
                    order_q.push_back(k);
            end
            CMD_PULL:
            begin
                if (order_q.size() == 0)
                begin
                    r.status  = STS_EMPTY;
                    r.key_out = 32'h0;
                end
                else
                    r.key_out = order_q.pop_front();
            end
            CMD_REMOVE:
            begin
                if (hit < 0)
                    r.status = STS_NOT_FOUND;
                else
                    order_q.delete(hit);
            end
            default:
            begin
                // tail already matching leaves the order alone
                if (hit < 0)
                    r.status = STS_NOT_FOUND;
                else if (order_q[order_q.size() - 1] != k)
                begin
                    order_q.delete(hit);
                    order_q.push_back(k);
                end
            end
        endcase
        r.occupancy = 5'(order_q.size());
        return r;
    endfunction

    task automatic send_command(input cmd_t c, input logic [31:0] k, input logic typed,
                                input qresult_t want);
        qresult_t predicted;
        int       gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_valid <= 1'b1;
        cmd      <= c;
        key      <= k;
        do
            @(posedge clk);
        while (in_stall);
        predicted = predict_order(c, k);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // receiver stall pattern, cycling through four characters set by stall_cycle[7:6]
    always @(posedge clk)
    begin
        stall_cycle <= stall_cycle + 8'd1;
        case (stall_cycle[7:6])
            2'd0:    out_stall <= 1'b0;
            2'd1:    out_stall <= ($urandom_range(1) == 1);
            2'd2:    out_stall <= (stall_cycle[1:0] != 2'd0);
            default: out_stall <= ($urandom_range(3) == 0);
        endcase
    end

    always @(posedge clk)
    begin : check_result
        qresult_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                if (error_count < 10)
                    $display("unexpected result: key_out %h status %0d occupancy %0d",
                             key_out, status, occupancy);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (key_out !== want.key_out || status !== want.status
                    || occupancy !== want.occupancy)
                begin
                    if (error_count < 10)
                        $display("mismatch: key_out %h/%h status %0d/%0d occupancy %0d/%0d",
                                 want.key_out, key_out, want.status, status,
                                 want.occupancy, occupancy);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_keyed_fifo_with_remove_and_bump: errors");
            $finish;
        end
    end

    initial
    begin
        cmd_t        c;
        logic [31:0] k;
        int          fill_bias;
        int          pick;
        fill_bias = 30;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[n])
            send_command(DIRECTED_ROWS[n].cmd, DIRECTED_ROWS[n].key,
                         DIRECTED_ROWS[n].typed, DIRECTED_ROWS[n].want);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // swing the fill level toward full, then toward empty
            if (i % 60 == 0)
                fill_bias = (fill_bias > 50) ? $urandom_range(15, 35) : $urandom_range(60, 80);
            if (i == RANDOM_ITEMS / 2)
            begin
                in_valid <= 1'b0;
                burst_left = 0;
                do
                    @(posedge clk);
                while (pending_results.size() != 0);
            end
            pick = $urandom_range(99);
            if (pick < fill_bias)
                c = CMD_PUT;
            else
            begin
                case ($urandom_range(2))
                    0:       c = CMD_PULL;
                    1:       c = CMD_REMOVE;
                    default: c = CMD_BUMP;
                endcase
            end
            pick = $urandom_range(99);
            if (order_q.size() != 0 && pick < 55)
                k = order_q[$urandom_range(order_q.size() - 1)];
            else if (pick < 85)
                k = 32'($urandom_range(7));
            else
                k = $urandom;
            send_command(c, k, 1'b0, '0);
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("tb_keyed_fifo_with_remove_and_bump: clean");
        else
            $display("tb_keyed_fifo_with_remove_and_bump: errors");
        $finish;
    end

endmodule

@@ keyed_fifo_with_remove_and_bump.f @@
hw/rtl/kfq_pkg.sv
hw/rtl/kfq_cell.sv
hw/rtl/keyed_fifo_with_remove_and_bump.sv
tb/tb_keyed_fifo_with_remove_and_bump.sv
